// ----- hw/rtl/cvu_pkg.sv -----
// Shared constants, types and codes of the cost volume update block.
// No dependencies; every other file imports this package.
package cvu_pkg;

  localparam int PIXELS  = 65536;
  localparam int LAYERS  = 32;
  localparam int ENTRIES = PIXELS * LAYERS;
  localparam int ADDR_W  = $clog2(ENTRIES);

  localparam int PIX_W  = 16;
  localparam int LAY_W  = 5;
  localparam int CH_W   = 16;
  localparam int COST_W = 48;
  localparam int HITS_W = 16;
  localparam int SQ_W   = 2 * CH_W;
  localparam int SAD_W  = CH_W + 2;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
  localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};

  // divider: numerator covers cost - sad + hits - 1, two quotient bits per stage
  localparam int NUM_W      = COST_W + 2;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = NUM_W / DIV_BITS;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE = 1'd1;

  typedef struct packed {
    logic              norm;
    logic              colour;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              in_range;
    logic              visible;
    logic [CH_W-1:0]   d_r;
    logic [CH_W-1:0]   d_g;
    logic [CH_W-1:0]   d_b;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic              wr;
    logic              in_range;
    logic              visible;
    logic              norm;
    logic              ge;
    logic [ADDR_W-1:0] addr;
    logic [COST_W-1:0] cost;
    logic [COST_W-1:0] l2_cost;
    logic [HITS_W-1:0] hits_new;
    logic [HITS_W-1:0] hits_old;
  } side_t;

endpackage

// ----- hw/rtl/cvu_front.sv -----
// Front classifier: entry address, range check and absolute channel differences.
// Depends on cvu_pkg.
module cvu_front import cvu_pkg::*; (
  input  logic [PIX_W-1:0] pixel_index,
  input  logic [LAY_W-1:0] layer_index,
  input  logic             visible,
  input  logic [CH_W-1:0]  warped_r,
  input  logic [CH_W-1:0]  warped_g,
  input  logic [CH_W-1:0]  warped_b,
  input  logic [CH_W-1:0]  ref_r,
  input  logic [CH_W-1:0]  ref_g,
  input  logic [CH_W-1:0]  ref_b,
  output item_t            item
);

  function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  logic [31:0] addr_full;

  assign addr_full = 32'(pixel_index) * 32'(LAYERS) + 32'(layer_index);

  always_comb begin
    item.addr     = addr_full[ADDR_W-1:0];
    item.in_range = (32'(pixel_index) < 32'(PIXELS)) && (32'(layer_index) < 32'(LAYERS));
    item.visible  = visible;
    item.d_r      = absdiff(warped_r, ref_r);
    item.d_g      = absdiff(warped_g, ref_g);
    item.d_b      = absdiff(warped_b, ref_b);
  end

endmodule

// ----- hw/rtl/cvu_queue.sv -----
// Short FIFO between the front classifier and the update pipeline.
// Depends on cvu_pkg.
module cvu_queue import cvu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item,
  output logic  full
);

  item_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign head_valid = (count != '0);
  assign full       = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end
  end

endmodule

// ----- hw/rtl/cvu_div.sv -----
// Pipelined unsigned divider, two quotient bits per stage, one division per cycle.
// Depends on cvu_pkg.
module cvu_div import cvu_pkg::*; (
  input  logic              clk,
  input  logic [NUM_W-1:0]  num,
  input  logic [HITS_W-1:0] den,
  output logic [NUM_W-1:0]  quo
);

  logic [NUM_W-1:0]  n_q [DIV_STAGES];
  logic [HITS_W:0]   r_q [DIV_STAGES];
  logic [HITS_W-1:0] d_q [DIV_STAGES];

  function automatic logic [NUM_W+HITS_W:0] step(input logic [NUM_W-1:0]  n_in,
                                                  input logic [HITS_W:0]   r_in,
                                                  input logic [HITS_W-1:0] d);
    logic [NUM_W-1:0] n;
    logic [HITS_W+1:0] r;
    n = n_in;
    r = {1'b0, r_in};
    for (int j = 0; j < DIV_BITS; j++) begin
      r = {r[HITS_W:0], n[NUM_W-1]};
      n = {n[NUM_W-2:0], 1'b0};
      if (r >= {2'b00, d}) begin
        r = r - {2'b00, d};
        n[0] = 1'b1;
      end
    end
    return {n, r[HITS_W:0]};
  endfunction

  always_ff @(posedge clk) begin
    {n_q[0], r_q[0]} <= step(num, '0, den);
    d_q[0] <= den;
    for (int k = 1; k < DIV_STAGES; k++) begin
      {n_q[k], r_q[k]} <= step(n_q[k-1], r_q[k-1], d_q[k-1]);
      d_q[k] <= d_q[k-1];
    end
  end

  assign quo = n_q[DIV_STAGES-1];

endmodule

// ----- hw/rtl/cvu_back.sv -----
// Update pipeline: entry memory with clearing sweep, hazard check, cost math,
// divider and write-back. Depends on cvu_pkg and cvu_div.
module cvu_back import cvu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              head_valid,
  input  item_t             head_item,
  output logic              pop,
  output logic              clearing,
  output logic              done,
  output logic [COST_W-1:0] cost_out,
  output logic [HITS_W-1:0] hits_out,
  output logic              entry_updated
);

  logic [HITS_W+COST_W-1:0] mem [ENTRIES];
  logic [HITS_W+COST_W-1:0] rd_q;
  logic [ADDR_W:0]          clr_cnt;

  logic              s1_valid;
  item_t             s1_item;
  logic              s2_valid;
  item_t             s2_item;
  logic [HITS_W+COST_W-1:0] s2_word;
  logic [SQ_W-1:0]   sq_r, sq_g, sq_b;

  side_t             side_d;
  side_t             side_q [DIV_STAGES];
  logic [NUM_W-1:0]  num_d;
  logic [NUM_W-1:0]  quo;

  logic              hazard;
  logic              wr_en;
  logic [COST_W-1:0] cost_new;

  // stall the head while any in-flight write targets the same entry
  always_comb begin
    hazard = (s1_valid && s1_item.in_range && s1_item.visible &&
              s1_item.addr == head_item.addr) ||
             (s2_valid && s2_item.in_range && s2_item.visible &&
              s2_item.addr == head_item.addr);
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (side_q[k].valid && side_q[k].wr && side_q[k].addr == head_item.addr) begin
        hazard = 1'b1;
      end
    end
  end

  assign pop = head_valid && !clearing && !(head_item.in_range && hazard);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt[ADDR_W-1:0] == ADDR_W'(ENTRIES - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[ADDR_W-1:0]] <= '0;
    end else if (wr_en) begin
      mem[side_q[DIV_STAGES-1].addr] <= {side_q[DIV_STAGES-1].hits_new, cost_new};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.in_range) begin
      rd_q <= mem[head_item.addr];
    end
  end

  // stage 1: squares
  always_ff @(posedge clk) begin
    s1_item  <= head_item;
    s2_item  <= s1_item;
    s2_word  <= rd_q;
    sq_r     <= SQ_W'(s1_item.d_r) * SQ_W'(s1_item.d_r);
    sq_g     <= SQ_W'(s1_item.d_g) * SQ_W'(s1_item.d_g);
    sq_b     <= SQ_W'(s1_item.d_b) * SQ_W'(s1_item.d_b);
  end

  // stage 2: hit count, difference sign, divider numerator, L2 sum
  always_comb begin
    logic [COST_W-1:0] cost;
    logic [HITS_W-1:0] hits;
    logic [SAD_W-1:0]  sad;
    logic [SQ_W+1:0]   sq_sum;
    logic [COST_W:0]   l2_sum;
    cost   = s2_word[COST_W-1:0];
    hits   = s2_word[HITS_W+COST_W-1:COST_W];
    sad    = SAD_W'(s2_item.d_r) + SAD_W'(s2_item.d_g) + SAD_W'(s2_item.d_b);
    sq_sum = (SQ_W+2)'(sq_r);
    if (cfg.colour) sq_sum = sq_sum + (SQ_W+2)'(sq_g) + (SQ_W+2)'(sq_b);
    l2_sum = (COST_W+1)'(cost) + (COST_W+1)'(sq_sum);

    side_d.valid    = s2_valid;
    side_d.wr       = s2_item.in_range && s2_item.visible;
    side_d.in_range = s2_item.in_range;
    side_d.visible  = s2_item.visible;
    side_d.norm     = cfg.norm;
    side_d.addr     = s2_item.addr;
    side_d.cost     = cost;
    side_d.hits_old = hits;
    side_d.hits_new = (hits == HITS_MAX) ? HITS_MAX : hits + 1'b1;
    side_d.l2_cost  = l2_sum[COST_W] ? COST_MAX : l2_sum[COST_W-1:0];
    side_d.ge       = (COST_W'(sad) >= cost);
    if (side_d.ge) begin
      num_d = NUM_W'(COST_W'(sad) - cost);
    end else begin
      num_d = NUM_W'(cost - COST_W'(sad)) + NUM_W'(side_d.hits_new) - 1'b1;
    end
  end

  cvu_div u_div (
    .clk (clk),
    .num (num_d),
    .den (side_d.hits_new),
    .quo (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) side_q[k] <= '0;
    end else begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      side_q[0] <= side_d;
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // write-back and result
  always_comb begin
    side_t t;
    t = side_q[DIV_STAGES-1];
    if (t.norm) begin
      cost_new = t.l2_cost;
    end else if (t.ge) begin
      cost_new = t.cost + quo[COST_W-1:0];
    end else begin
      cost_new = t.cost - quo[COST_W-1:0];
    end
    wr_en = t.valid && t.wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_q[DIV_STAGES-1].valid;
    end
    if (!side_q[DIV_STAGES-1].in_range) begin
      cost_out <= '0;
      hits_out <= '0;
    end else if (!side_q[DIV_STAGES-1].visible) begin
      cost_out <= side_q[DIV_STAGES-1].cost;
      hits_out <= side_q[DIV_STAGES-1].hits_old;
    end else begin
      cost_out <= cost_new;
      hits_out <= side_q[DIV_STAGES-1].hits_new;
    end
    entry_updated <= wr_en;
  end

endmodule

// ----- hw/rtl/cost_volume_update.sv -----
// Top level of the cost volume update block: config registers, front, queue, back.
// Depends on cvu_pkg, cvu_front, cvu_queue, cvu_back.
//
// Usage:
//   Input words are taken at a rising edge with start high and busy low. Each word
//   names one cost-volume entry (pixel_index * LAYERS + layer_index) and carries
//   the warped and reference colours plus the visibility bit.
//   Every word yields one result word: done is high for one cycle with cost_out,
//   hits_out and entry_updated; the receiver cannot stall, so results just go.
//   From the accepting edge to done high a word passes through the queue, the
//   memory read, squares and prep, 25 divider stages at two quotient bits each,
//   the last one feeding the write-back and result registers.
//   Throughput is one word per cycle unless a word must wait: a word whose entry
//   is still being updated by an earlier word waits in the queue until that write
//   lands, so repeated hits on one entry are paced by the divider depth.
//   busy is high while the four-word queue is full.
//   Reset starts a clearing sweep of the entry memory, one entry per cycle, over
//   all 2^21 entries at the default size; busy stays high during the sweep.
//   Config writes (cfg_we, cfg_index, cfg_data) land at once and are meant
//   for idle periods only.
module cost_volume_update import cvu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [PIX_W-1:0]     pixel_index,
  input  logic [LAY_W-1:0]     layer_index,
  input  logic                 visible,
  input  logic [CH_W-1:0]      warped_r,
  input  logic [CH_W-1:0]      warped_g,
  input  logic [CH_W-1:0]      warped_b,
  input  logic [CH_W-1:0]      ref_r,
  input  logic [CH_W-1:0]      ref_g,
  input  logic [CH_W-1:0]      ref_b,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  output logic                 done,
  output logic [COST_W-1:0]    cost_out,
  output logic [HITS_W-1:0]    hits_out,
  output logic                 entry_updated
);

  cfg_t  cfg;
  item_t front_item;
  item_t head_item;
  logic  head_valid;
  logic  q_full;
  logic  pop;
  logic  clearing;
  logic  accept;

  // config registers: norm_mode resets to L1, colour_mode to three channels
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.norm   <= 1'b0;
      cfg.colour <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NORM_MODE:   cfg.norm   <= cfg_data;
        CFG_COLOUR_MODE: cfg.colour <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold off new words during the sweep and while the queue is full
  assign busy   = clearing || q_full;
  assign accept = start && !busy;

  cvu_front u_front (
    .pixel_index (pixel_index),
    .layer_index (layer_index),
    .visible     (visible),
    .warped_r    (warped_r),
    .warped_g    (warped_g),
    .warped_b    (warped_b),
    .ref_r       (ref_r),
    .ref_g       (ref_g),
    .ref_b       (ref_b),
    .item        (front_item)
  );

  cvu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_item  (front_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .full       (q_full)
  );

  cvu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .clearing      (clearing),
    .done          (done),
    .cost_out      (cost_out),
    .hits_out      (hits_out),
    .entry_updated (entry_updated)
  );

endmodule

// ----- hw/rtl/cvu_checker.sv -----
// Port-level checks of the cost volume update block, bound to the top level.
// Depends on cvu_pkg and cost_volume_update.
module cvu_checker import cvu_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              done,
  input logic [COST_W-1:0] cost_out,
  input logic [HITS_W-1:0] hits_out,
  input logic              entry_updated
);

  // reset starts the clearing sweep
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy not raised after reset");

  // nothing is in flight right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result word right after reset");

  // an updated entry always carries at least one hit
  a_upd_hits: assert property (@(posedge clk) disable iff (rst)
    done && entry_updated |-> hits_out != '0)
    else $error("updated entry with zero hits");

  // an entry never hit holds zero cost
  a_zero_cost: assert property (@(posedge clk) disable iff (rst)
    done && hits_out == '0 |-> cost_out == '0)
    else $error("nonzero cost on an entry without hits");

endmodule

bind cost_volume_update cvu_checker u_cvu_checker (.*);

// ----- bench/tb_cost_volume_update.sv -----
// Self-checking bench for cost_volume_update: directed and random entry updates in
// L1, L2 colour and L2 grey modes, checked against an in-bench cost volume predictor.
// Depends on cvu_pkg and the cost_volume_update RTL.
`timescale 1ns / 1ps

module tb_cost_volume_update;
  import cvu_pkg::*;

  typedef struct {
    logic [COST_W-1:0] cost;
    logic [HITS_W-1:0] hits;
    logic              updated;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [PIX_W-1:0]     pixel_index = '0;
  logic [LAY_W-1:0]     layer_index = '0;
  logic                 visible = 1'b0;
  logic [CH_W-1:0]      warped_r = '0, warped_g = '0, warped_b = '0;
  logic [CH_W-1:0]      ref_r = '0, ref_g = '0, ref_b = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NORM_MODE;
  logic                 cfg_data = 1'b0;
  logic                 done;
  logic [COST_W-1:0]    cost_out;
  logic [HITS_W-1:0]    hits_out;
  logic                 entry_updated;

  cost_volume_update dut (.*);

  // Predictor state: the cost volume as sparse maps, plus the mode registers.
  logic [COST_W-1:0] cost_mem [int unsigned];
  logic [HITS_W-1:0] hit_mem [int unsigned];
  logic              pred_norm = 1'b0;
  logic              pred_colour = 1'b1;
  result_t           pending_results[$];
  int                errors = 0;
  int                words_sent = 0;
  int                results_seen = 0;
  int                updates_seen = 0;
  bit                no_gaps = 1'b0;

  // Pool of entries reused by the random part so hit counts climb.
  logic [PIX_W-1:0] pool_pix [8];
  logic [LAY_W-1:0] pool_lay [8];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [CH_W-1:0] absdiff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Update the predicted entry and return what the block should report.
  function automatic result_t update_entry(logic [PIX_W-1:0] pix, logic [LAY_W-1:0] lay,
      logic vis, logic [CH_W-1:0] wr, logic [CH_W-1:0] wg, logic [CH_W-1:0] wb,
      logic [CH_W-1:0] rr, logic [CH_W-1:0] rg, logic [CH_W-1:0] rb);
    int unsigned addr;
    logic [63:0] cost, hits, sad, sq, d;
    result_t     res;
    addr = pix * LAYERS + lay;
    cost = cost_mem.exists(addr) ? cost_mem[addr] : '0;
    hits = hit_mem.exists(addr) ? hit_mem[addr] : '0;
    if (!vis) begin
      res.cost = cost[COST_W-1:0];
      res.hits = hits[HITS_W-1:0];
      res.updated = 1'b0;
      return res;
    end
    hits = (hits < HITS_MAX) ? hits + 1 : HITS_MAX;
    if (!pred_norm) begin
      sad = absdiff(wr, rr) + absdiff(wg, rg) + absdiff(wb, rb);
      if (sad >= cost) cost = cost + (sad - cost) / hits;
      else cost = cost - ((cost - sad) + hits - 1) / hits;
    end else begin
      d = absdiff(wr, rr);
      sq = d * d;
      if (pred_colour) begin
        d = absdiff(wg, rg);
        sq += d * d;
        d = absdiff(wb, rb);
        sq += d * d;
      end
      cost = cost + sq;
      if (cost > COST_MAX) cost = COST_MAX;
    end
    cost_mem[addr] = cost[COST_W-1:0];
    hit_mem[addr] = hits[HITS_W-1:0];
    res.cost = cost[COST_W-1:0];
    res.hits = hits[HITS_W-1:0];
    res.updated = 1'b1;
    return res;
  endfunction

  // Send one word: idle a random gap, present it, hold until busy drops at an edge.
  task automatic send_word(logic [PIX_W-1:0] pix, logic [LAY_W-1:0] lay, logic vis,
      logic [CH_W-1:0] wr, logic [CH_W-1:0] wg, logic [CH_W-1:0] wb,
      logic [CH_W-1:0] rr, logic [CH_W-1:0] rg, logic [CH_W-1:0] rb);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pixel_index <= pix;
    layer_index <= lay;
    visible <= vis;
    warped_r <= wr; warped_g <= wg; warped_b <= wb;
    ref_r <= rr; ref_g <= rg; ref_b <= rb;
    // busy only moves after a rising edge, so the low phase shows what the edge sees
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_results.push_back(update_entry(pix, lay, vis, wr, wg, wb, rr, rg, rb));
    words_sent++;
  endtask

  // Drop start, then wait out every expected result plus the pipeline tail.
  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NORM_MODE) pred_norm = val;
    else pred_colour = val;
  endtask

  task automatic set_modes(logic norm, logic colour);
    drain();
    write_reg(CFG_NORM_MODE, norm);
    write_reg(CFG_COLOUR_MODE, colour);
  endtask

  // Random word: mostly visible updates to pooled entries, some anywhere, some hidden.
  task automatic send_random_word;
    int               k;
    logic [PIX_W-1:0] pix;
    logic [LAY_W-1:0] lay;
    logic [CH_W-1:0]  wr, wg, wb, rr, rg, rb;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      pix = pool_pix[k];
      lay = pool_lay[k];
    end else begin
      pix = $urandom;
      lay = $urandom;
    end
    wr = $urandom; wg = $urandom; wb = $urandom;
    rr = $urandom; rg = $urandom; rb = $urandom;
    // close colours keep L1 means small so both the rise and fall paths get used
    if ($urandom_range(0, 2) == 0) begin
      rr = wr ^ CH_W'($urandom_range(0, 255));
      rg = wg ^ CH_W'($urandom_range(0, 255));
      rb = wb ^ CH_W'($urandom_range(0, 255));
    end
    send_word(pix, lay, $urandom_range(0, 7) != 0, wr, wg, wb, rr, rg, rb);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      // every so often run a stretch back to back
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      send_random_word();
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_l1_directed;
    set_modes(1'b0, 1'b1);
    // corner addresses, max and zero SAD, then a falling mean on one entry
    send_word(16'h0000, 5'd0, 1'b1, '1, '1, '1, '0, '0, '0);
    send_word(16'hFFFF, 5'd31, 1'b1, '0, '0, '0, '1, '1, '1);
    send_word(16'h0000, 5'd0, 1'b1, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234,
              16'h1234);
    send_word(16'h0000, 5'd0, 1'b1, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              16'h0000);
    send_word(16'hFFFF, 5'd31, 1'b1, '1, '1, '1, '1, '1, '1);
    // hidden words: report the entry, touch nothing; also an entry never written
    send_word(16'h0000, 5'd0, 1'b0, '1, '0, '1, '0, '1, '0);
    send_word(16'h7F3A, 5'd17, 1'b0, '0, '0, '0, '1, '1, '1);
    send_word(16'hFFFF, 5'd0, 1'b1, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000,
              16'h0001);
  endtask

  task automatic test_l2_colour_directed;
    set_modes(1'b1, 1'b1);
    // switching mode reuses the stored L1 mean as it is
    send_word(16'h0000, 5'd0, 1'b1, '1, '1, '1, '0, '0, '0);
    send_word(16'h0000, 5'd0, 1'b1, '1, '1, '1, '0, '0, '0);
    send_word(16'h0001, 5'd1, 1'b1, 16'h0100, 16'h0200, 16'h0300, 16'h0000, 16'h0000,
              16'h0000);
    send_word(16'h0001, 5'd1, 1'b0, '0, '0, '0, '0, '0, '0);
  endtask

  task automatic test_l2_grey_directed;
    set_modes(1'b1, 1'b0);
    // green and blue must not count in grey mode
    send_word(16'h0002, 5'd2, 1'b1, 16'h0010, '1, '1, 16'h0000, '0, '0);
    send_word(16'h0002, 5'd2, 1'b1, '0, '0, '0, '1, '1, '1);
    send_word(16'hFFFF, 5'd31, 1'b1, '1, 16'h1111, 16'h2222, '0, 16'h3333, 16'h4444);
    // back to L1 on an entry holding an L2 sum
    set_modes(1'b0, 1'b0);
    send_word(16'h0002, 5'd2, 1'b1, '0, '0, '0, '0, '0, '0);
    send_word(16'h0002, 5'd2, 1'b1, '1, '1, '1, '0, '0, '0);
  endtask

  task automatic test_random_modes;
    for (int i = 0; i < 8; i++) begin
      pool_pix[i] = $urandom;
      pool_lay[i] = $urandom;
    end
    set_modes(1'b0, 1'b1);
    run_random(400);
    set_modes(1'b1, 1'b1);
    run_random(350);
    set_modes(1'b1, 1'b0);
    run_random(250);
    set_modes(1'b0, 1'b0);
    run_random(330);
  endtask

  // Check each result word against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%t: unexpected result cost=%h hits=%h upd=%b", $realtime, cost_out,
                 hits_out, entry_updated);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (entry_updated) updates_seen++;
        if (cost_out !== want.cost) begin
          $display("%t: cost_out expected %h actual %h", $realtime, want.cost, cost_out);
          errors++;
        end
        if (hits_out !== want.hits) begin
          $display("%t: hits_out expected %h actual %h", $realtime, want.hits, hits_out);
          errors++;
        end
        if (entry_updated !== want.updated) begin
          $display("%t: entry_updated expected %b actual %b", $realtime, want.updated,
                   entry_updated);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // hold off until the clearing sweep ends
    do @(negedge clk); while (busy);
    @(posedge clk);
    test_l1_directed();
    test_l2_colour_directed();
    test_l2_grey_directed();
    test_random_modes();
    drain();
    if (pending_results.size() != 0) errors++;
    $display("Covered %0d words (%0d results, %0d entry updates) over L1, L2 colour",
             words_sent, results_seen, updates_seen);
    $display("and L2 grey modes, with mode switches on live entries.");
    if (errors == 0) $display("tb_cost_volume_update: clean");
    else $display("tb_cost_volume_update: errors");
    $finish;
  end

  // Timeout covering the clearing sweep of every entry plus the traffic, several times over.
  initial begin
    #80_000_000;
    $display("tb_cost_volume_update: errors");
    $finish;
  end

endmodule
